### src/escaped_packet_framer_assert.svh
// ----------------------------------------------------------------------------
// escaped_packet_framer_assert.svh
// Assertion macros for the escaped packet framer.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_PACKET_FRAMER_ASSERT_SVH
`define ESCAPED_PACKET_FRAMER_ASSERT_SVH

// implication checked every clock, masked while in reset
`define EPF_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition that must never be true
`define EPF_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

### src/epf_pkg.sv
// ----------------------------------------------------------------------------
// epf_pkg
// Types and constants shared by the escaped packet framer modules.
// ----------------------------------------------------------------------------
package epf_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;

	localparam logic [7:0] START_RESET = 8'h7F;
	localparam logic [7:0] POLL_RESET  = 8'h8F;
	localparam logic [7:0] FLAG_RESET  = 8'h8E;

	localparam logic [7:0] ESC_START_CODE = 8'h01;
	localparam logic [7:0] ESC_POLL_CODE  = 8'h02;

	localparam logic [1:0] CFG_START = 2'd0;
	localparam logic [1:0] CFG_POLL  = 2'd1;
	localparam logic [1:0] CFG_FLAG  = 2'd2;

	localparam logic CMD_OPEN = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	typedef enum logic [2:0] {
		ST_START,
		ST_DEV,
		ST_SRC,
		ST_TYP,
		ST_LENH,
		ST_LENL,
		ST_DATA,
		ST_CSUM
	} step_t;

	typedef struct packed {
		logic [7:0] start_byte;
		logic [7:0] poll_byte;
		logic [7:0] flag_byte;
	} cfg_t;

	// one byte to send, raw or through the escaper
	typedef struct packed {
		logic [7:0] value;
		logic       raw;
		logic       last;
		logic       fend;
	} task_t;

endpackage

### src/epf_fifo.sv
// ----------------------------------------------------------------------------
// epf_fifo
// Short task queue between the framer front end and the byte emitter.
// ----------------------------------------------------------------------------
module epf_fifo import epf_pkg::*; #(
	parameter int unsigned DEPTH = QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  task_t push_data,
	output logic  push_ready,
	input  logic  pop,
	output task_t pop_data,
	output logic  pop_valid
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	task_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### src/epf_front.sv
// ----------------------------------------------------------------------------
// epf_front
// Accepts items, tracks packet state and checksum, issues byte tasks.
// ----------------------------------------------------------------------------
module epf_front import epf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  device_id,
	input  logic [7:0]  source_id,
	input  logic [7:0]  packet_type,
	input  logic [15:0] payload_length,
	input  logic [7:0]  data_byte,
	output logic        q_push,
	output task_t       q_data,
	input  logic        q_ready
);

	logic        open_q;
	logic [15:0] remain_q;
	logic [7:0]  sum_q;

	logic        busy_q;
	step_t       step_q;
	logic        csum_q;
	logic [7:0]  dev_q;
	logic [7:0]  src_q;
	logic [7:0]  typ_q;
	logic [15:0] len_q;
	logic [7:0]  data_q;
	logic [7:0]  cs_q;

	logic        fin;
	logic        accept;
	logic        is_open;
	logic        is_data;
	logic [15:0] rem_dec;
	logic [7:0]  sum_new;
	logic        closing;
	step_t       step_next;

	always_comb begin
		q_data      = '0;
		q_data.raw  = 1'b0;
		fin         = 1'b0;
		step_next   = step_q;
		case (step_q)
			ST_START: begin
				q_data.value = cfg.start_byte;
				q_data.raw   = 1'b1;
				step_next    = ST_DEV;
			end
			ST_DEV: begin
				q_data.value = dev_q;
				step_next    = ST_SRC;
			end
			ST_SRC: begin
				q_data.value = src_q;
				step_next    = ST_TYP;
			end
			ST_TYP: begin
				q_data.value = typ_q;
				step_next    = ST_LENH;
			end
			ST_LENH: begin
				q_data.value = len_q[15:8];
				step_next    = ST_LENL;
			end
			ST_LENL: begin
				q_data.value = len_q[7:0];
				q_data.last  = !csum_q;
				fin          = !csum_q;
				step_next    = ST_CSUM;
			end
			ST_DATA: begin
				q_data.value = data_q;
				q_data.last  = !csum_q;
				fin          = !csum_q;
				step_next    = ST_CSUM;
			end
			ST_CSUM: begin
				q_data.value = cs_q;
				q_data.last  = 1'b1;
				q_data.fend  = 1'b1;
				fin          = 1'b1;
			end
			default: begin
				fin = 1'b1;
			end
		endcase
	end

	assign q_push   = busy_q;
	assign in_stall = busy_q && !(q_ready && fin);
	assign accept   = in_valid && !in_stall;
	assign is_open  = accept && (command == CMD_OPEN);
	assign is_data  = accept && (command == CMD_DATA) && open_q;
	assign rem_dec  = remain_q - 16'd1;

	always_comb begin
		if (command == CMD_OPEN) begin
			sum_new = cfg.start_byte + device_id + source_id + packet_type
				+ payload_length[15:8] + payload_length[7:0];
			closing = (payload_length == '0);
		end else begin
			sum_new = sum_q + data_byte;
			closing = (rem_dec == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (is_open || is_data) begin
			cs_q   <= 8'd0 - sum_new;
			csum_q <= closing;
		end
		if (is_open) begin
			dev_q <= device_id;
			src_q <= source_id;
			typ_q <= packet_type;
			len_q <= payload_length;
		end
		if (is_data) begin
			data_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			remain_q <= '0;
			sum_q    <= '0;
			busy_q   <= 1'b0;
			step_q   <= ST_START;
		end else begin
			if (is_open || is_data) begin
				busy_q <= 1'b1;
				step_q <= is_open ? ST_START : ST_DATA;
				if (closing) begin
					open_q   <= 1'b0;
					remain_q <= '0;
					sum_q    <= '0;
				end else begin
					open_q   <= 1'b1;
					remain_q <= is_open ? payload_length : rem_dec;
					sum_q    <= sum_new;
				end
			end else if (busy_q && q_ready) begin
				if (fin) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_next;
				end
			end
		end
	end

endmodule

### src/epf_back.sv
// ----------------------------------------------------------------------------
// epf_back
// Byte emitter: escapes queued bytes and drives the output register.
// ----------------------------------------------------------------------------
module epf_back import epf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  task_t      q_data,
	input  logic       q_valid,
	output logic       q_pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       frame_end
);

	logic       second_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       fend_q;

	logic       adv;
	logic       hit_start;
	logic       hit_poll;
	logic       hit_flag;
	logic       esc;
	logic [7:0] code;

	assign hit_start = (q_data.value == cfg.start_byte);
	assign hit_poll  = (q_data.value == cfg.poll_byte);
	assign hit_flag  = (q_data.value == cfg.flag_byte);
	assign esc       = !q_data.raw && (hit_start || hit_poll || hit_flag);

	always_comb begin
		if (hit_start) begin
			code = ESC_START_CODE;
		end else if (hit_poll) begin
			code = ESC_POLL_CODE;
		end else begin
			code = cfg.flag_byte;
		end
	end

	assign adv   = !valid_q || !out_stall;
	assign q_pop = adv && q_valid && (second_q || !esc);

	always_ff @(posedge clk) begin
		if (adv && q_valid) begin
			if (second_q) begin
				byte_q <= code;
				last_q <= q_data.last;
				fend_q <= q_data.fend;
			end else if (esc) begin
				byte_q <= cfg.flag_byte;
				last_q <= 1'b0;
				fend_q <= 1'b0;
			end else begin
				byte_q <= q_data.value;
				last_q <= q_data.last;
				fend_q <= q_data.fend;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (adv) begin
			valid_q <= q_valid;
			if (q_valid) begin
				second_q <= !second_q && esc;
			end
		end
	end

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;
	assign frame_end   = fend_q;

endmodule

### src/escaped_packet_framer.sv
// ----------------------------------------------------------------------------
// escaped_packet_framer
// Byte-stuffing packet framer with two's complement checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): command 0 opens a packet with its
//   header fields, command 1 carries one payload byte. Payload with no open
//   packet is dropped; a new open abandons the current packet.
//   Output channel (out_valid/out_stall): one wire byte per transfer, with
//   last_of_run on the final byte of an input item and frame_end on the
//   final checksum byte.
//   Config channel (cfg_valid/cfg_ready, always ready): index 0 start,
//   1 poll, 2 flag byte; write only while idle.
// Flow:
//   The first output byte passes the front end's state registers, the
//   task queue and the output register. The front end issues one byte task
//   per cycle while the queue has room (6-7 for an open, 1-2 for a payload
//   byte); the emitter sends one wire byte per cycle while out_stall is
//   low, and an escaped byte goes out as two wire bytes.
// Reset clears packet state, the task queue and the output register;
// config returns to 0x7F/0x8F/0x8E. A stalled output holds its byte and
// the queue backs up into in_stall.
// ----------------------------------------------------------------------------
`include "escaped_packet_framer_assert.svh"

module escaped_packet_framer import epf_pkg::*; #(
	parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  device_id,
	input  logic [7:0]  source_id,
	input  logic [7:0]  packet_type,
	input  logic [15:0] payload_length,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        frame_end
);

	cfg_t  cfg_q;
	logic  push;
	task_t push_data;
	logic  push_ready;
	logic  pop;
	task_t pop_data;
	logic  pop_valid;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte <= START_RESET;
			cfg_q.poll_byte  <= POLL_RESET;
			cfg_q.flag_byte  <= FLAG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START: cfg_q.start_byte <= cfg_data;
				CFG_POLL:  cfg_q.poll_byte  <= cfg_data;
				CFG_FLAG:  cfg_q.flag_byte  <= cfg_data;
				default:   cfg_q <= cfg_q;
			endcase
		end
	end

	epf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.device_id      (device_id),
		.source_id      (source_id),
		.packet_type    (packet_type),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.q_push         (push),
		.q_data         (push_data),
		.q_ready        (push_ready)
	);

	epf_fifo #(
		.DEPTH (QDEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid)
	);

	epf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_data      (pop_data),
		.q_valid     (pop_valid),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.frame_end   (frame_end)
	);

	`EPF_ASSERT_IMPL(a_fend_is_last, out_valid && frame_end, last_of_run, "frame_end without last_of_run")
	`EPF_ASSERT_NEVER(a_no_pop_empty, pop && !pop_valid, "task popped from empty queue")
	`EPF_ASSERT_IMPL(a_accept_room, in_valid && !in_stall && push, push_ready, "item taken while queue full")

endmodule

### test/escaped_packet_framer_test.sv
// ----------------------------------------------------------------------------
// escaped_packet_framer_test
// Self-checking bench for the escaped packet framer. Sends open and payload
// transfers under several marker settings, predicts the stuffed wire stream
// with its checksum, and compares each output transfer in order while both
// sides idle at random and the receiver at one point holds off for a while.
// ----------------------------------------------------------------------------
module escaped_packet_framer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import epf_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int TARGET_ITEMS  = 420;
	localparam int LONG_HOLD     = 400;

	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       fend;
	} wire_byte_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [7:0]  cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        command;
	logic [7:0]  device_id;
	logic [7:0]  source_id;
	logic [7:0]  packet_type;
	logic [15:0] payload_length;
	logic [7:0]  data_byte;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        frame_end;

	// predicted wire stream and framer state
	wire_byte_t  wire_q[$];
	cfg_t        mark;
	logic [7:0]  sum_acc;
	logic [15:0] bytes_left;
	logic        pkt_open;

	int fail_count  = 0;
	int item_count  = 0;
	int cycle_count = 0;
	int hold_req    = 0;
	bit in_idle_on  = 1'b1;
	bit rx_idle_on  = 1'b1;

	escaped_packet_framer u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.device_id      (device_id),
		.source_id      (source_id),
		.packet_type    (packet_type),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.last_of_run    (last_of_run),
		.frame_end      (frame_end)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** escaped_packet_framer: FAILED **");
			$finish;
		end
	end

	// ---------------- prediction ----------------

	function automatic void put_wire(input logic [7:0] b);
		wire_byte_t w;
		w.value = b;
		w.last  = 1'b0;
		w.fend  = 1'b0;
		wire_q.push_back(w);
	endfunction

	function automatic void put_stuffed(input logic [7:0] b);
		if (b == mark.start_byte) begin
			put_wire(mark.flag_byte);
			put_wire(ESC_START_CODE);
		end else if (b == mark.poll_byte) begin
			put_wire(mark.flag_byte);
			put_wire(ESC_POLL_CODE);
		end else if (b == mark.flag_byte) begin
			put_wire(mark.flag_byte);
			put_wire(mark.flag_byte);
		end else begin
			put_wire(b);
		end
	endfunction

	function automatic void put_summed(input logic [7:0] b);
		put_stuffed(b);
		sum_acc = sum_acc + b;
	endfunction

	function automatic void tag_tail(input bit fend_bit);
		wire_byte_t w;
		w = wire_q[wire_q.size() - 1];
		if (fend_bit)
			w.fend = 1'b1;
		else
			w.last = 1'b1;
		wire_q[wire_q.size() - 1] = w;
	endfunction

	function automatic void put_checksum();
		put_stuffed(8'h00 - sum_acc);
		tag_tail(1'b1);
		pkt_open   = 1'b0;
		sum_acc    = 8'h00;
		bytes_left = 16'h0000;
	endfunction

	// returns 1 when the transfer produces wire bytes
	function automatic bit frame_item(input logic cmd, input logic [7:0] dev, src, typ,
			input logic [15:0] len, input logic [7:0] data);
		if (cmd == CMD_OPEN) begin
			pkt_open = 1'b1;
			put_wire(mark.start_byte);
			sum_acc = mark.start_byte;
			put_summed(dev);
			put_summed(src);
			put_summed(typ);
			put_summed(len[15:8]);
			put_summed(len[7:0]);
			bytes_left = len;
			if (len == 16'h0000)
				put_checksum();
		end else begin
			if (!pkt_open)
				return 1'b0;
			put_summed(data);
			bytes_left = bytes_left - 16'h0001;
			if (bytes_left == 16'h0000)
				put_checksum();
		end
		tag_tail(1'b0);
		return 1'b1;
	endfunction

	// ---------------- checking ----------------

	task automatic report_mismatch(input string what);
		fail_count++;
		if (fail_count <= 50)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	always @(posedge clk) begin : check_wire
		wire_byte_t exp_w;
		if (arst_n && out_valid && !out_stall) begin
			if (wire_q.size() == 0) begin
				report_mismatch($sformatf("unexpected transfer, out_byte %02h", out_byte));
			end else begin
				exp_w = wire_q.pop_front();
				if (out_byte !== exp_w.value)
					report_mismatch($sformatf("out_byte %02h, want %02h",
						out_byte, exp_w.value));
				if (last_of_run !== exp_w.last)
					report_mismatch($sformatf("last_of_run %b, want %b on byte %02h",
						last_of_run, exp_w.last, exp_w.value));
				if (frame_end !== exp_w.fend)
					report_mismatch($sformatf("frame_end %b, want %b on byte %02h",
						frame_end, exp_w.fend, exp_w.value));
			end
		end
	end

	// ---------------- receiver ----------------

	initial begin
		int stall_left;
		stall_left = 0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left == 0 && hold_req > 0) begin
				stall_left = hold_req;
				hold_req   = 0;
			end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 10);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// ---------------- sender ----------------

	task automatic send_item(input logic cmd, input logic [7:0] dev, src, typ,
			input logic [15:0] len, input logic [7:0] data);
		if (in_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid       <= 1'b1;
		command        <= cmd;
		device_id      <= dev;
		source_id      <= src;
		packet_type    <= typ;
		payload_length <= len;
		data_byte      <= data;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (frame_item(cmd, dev, src, typ, len, data))
			item_count++;
	endtask

	task automatic send_open(input logic [7:0] dev, src, typ, input logic [15:0] len);
		send_item(CMD_OPEN, dev, src, typ, len, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_data(input logic [7:0] b);
		send_item(CMD_DATA, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)), b);
	endtask

	// close any open packet, drain the stream, let in-flight work finish
	task automatic settle();
		if (pkt_open)
			send_open(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 16'h0000);
		in_valid <= 1'b0;
		while (wire_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mark(input logic [1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_START: mark.start_byte = val;
			CFG_POLL:  mark.poll_byte  = val;
			CFG_FLAG:  mark.flag_byte  = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_marks(input logic [7:0] s, p, f);
		write_mark(CFG_START, s);
		write_mark(CFG_POLL, p);
		write_mark(CFG_FLAG, f);
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0:       return mark.start_byte;
			1:       return mark.poll_byte;
			2:       return mark.flag_byte;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] rand_mark();
		case ($urandom_range(0, 3))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one-byte packet whose checksum lands on the given value
	task automatic hit_checksum(input logic [7:0] target);
		logic [7:0] dev, src, typ, pre;
		dev = pick_byte();
		src = pick_byte();
		typ = pick_byte();
		pre = mark.start_byte + dev + src + typ + 8'h00 + 8'h01;
		send_open(dev, src, typ, 16'h0001);
		send_data(8'h00 - target - pre);
	endtask

	task automatic rand_packet(input int max_len);
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		if (kind == 0 && !pkt_open) begin
			send_data(pick_byte());
		end else if (kind == 1) begin
			// random full-width length, cut short by the next open
			send_open(pick_byte(), pick_byte(), pick_byte(), 16'($urandom_range(0, 65535)));
			n = $urandom_range(0, 3);
			repeat (n) send_data(pick_byte());
		end else begin
			n = $urandom_range(0, max_len);
			send_open(pick_byte(), pick_byte(), pick_byte(), 16'(n));
			repeat (n) send_data(pick_byte());
		end
	endtask

	// ---------------- tests ----------------

	task automatic test_directed();
		send_data(8'hA5);
		send_open(8'h00, 8'hFF, 8'h00, 16'h0000);
		send_open(START_RESET, POLL_RESET, FLAG_RESET, {START_RESET, FLAG_RESET});
		send_open(8'hFF, 8'h00, 8'hFF, 16'hFFFF);
		send_data(FLAG_RESET);
		send_open(8'h01, 8'h02, 8'h03, 16'h0003);
		send_data(START_RESET);
		send_data(POLL_RESET);
		send_data(FLAG_RESET);
		send_open(8'h10, 8'h20, 8'h30, 16'h0002);
		send_data(8'h00);
		send_data(8'hFF);
		send_data(8'h55);
		hit_checksum(mark.start_byte);
		hit_checksum(mark.poll_byte);
		hit_checksum(mark.flag_byte);
		settle();
	endtask

	task automatic marker_phase(input logic [7:0] s, p, f);
		set_marks(s, p, f);
		repeat (3) rand_packet(5);
		hit_checksum(s);
		hit_checksum(p);
		hit_checksum(f);
		settle();
	endtask

	task automatic test_marker_settings();
		write_mark(CFG_UNUSED, 8'h5A);
		marker_phase(8'h00, 8'hFF, 8'h80);
		marker_phase(8'hFF, 8'h00, 8'h00);
		marker_phase(8'h55, 8'h55, 8'h55);
		marker_phase(8'h10, 8'h20, 8'h20);
		marker_phase(8'h7F, 8'h8F, 8'hFF);
	endtask

	task automatic test_backpressure();
		in_idle_on = 1'b0;
		hold_req   = LONG_HOLD;
		repeat (6) rand_packet(8);
		settle();
		in_idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		int packets;
		logic [7:0] s, p, f;
		packets = 0;
		while (item_count < TARGET_ITEMS) begin
			if (item_count > TARGET_ITEMS - 80) begin
				in_idle_on = 1'b0;
				rx_idle_on = 1'b0;
			end else if (packets % 15 == 0) begin
				settle();
				s = rand_mark();
				p = ($urandom_range(0, 7) == 0) ? s : rand_mark();
				f = ($urandom_range(0, 7) == 0) ? p : rand_mark();
				set_marks(s, p, f);
			end
			rand_packet(($urandom_range(0, 9) == 0) ? 40 : 6);
			packets++;
		end
		settle();
	endtask

	initial begin
		mark.start_byte = START_RESET;
		mark.poll_byte  = POLL_RESET;
		mark.flag_byte  = FLAG_RESET;
		sum_acc    = 8'h00;
		bytes_left = 16'h0000;
		pkt_open   = 1'b0;

		arst_n         <= 1'b0;
		cfg_valid      <= 1'b0;
		cfg_index      <= CFG_START;
		cfg_data       <= 8'h00;
		in_valid       <= 1'b0;
		command        <= CMD_OPEN;
		device_id      <= 8'h00;
		source_id      <= 8'h00;
		packet_type    <= 8'h00;
		payload_length <= 16'h0000;
		data_byte      <= 8'h00;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_marker_settings();
		test_backpressure();
		test_random_traffic();

		if (fail_count == 0) begin
			$display("** escaped_packet_framer: PASSED **");
		end else begin
			$display("** escaped_packet_framer: FAILED **");
		end
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/epf_pkg.sv
src/epf_fifo.sv
src/epf_front.sv
src/epf_back.sv
src/escaped_packet_framer.sv
test/escaped_packet_framer_test.sv
